@@ sv/msfd_pkg.sv @@
// ----------------------------------------------------------------------------
// msfd_pkg
// Shared types and constants of the Hall sensor frame decoder.
// ----------------------------------------------------------------------------
package msfd_pkg;

    localparam int unsigned CODE_W      = 12;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned TENTHS_W    = 16;
    localparam int unsigned SQ_W        = 2 * CODE_W;
    localparam int unsigned ROOT_W      = SQ_W / 2;
    localparam int unsigned REM_W       = ROOT_W + 1;

    // square root: two result bits resolved per register stage
    localparam int unsigned SQRT_BITS_PER_STAGE = 2;
    localparam int unsigned SQRT_STAGES         = ROOT_W / SQRT_BITS_PER_STAGE;

    // unpack, square, sum, then the root stages
    localparam int unsigned FRONT_STAGES = 3;
    localparam int unsigned LATENCY      = FRONT_STAGES + SQRT_STAGES;

    localparam logic signed [CODE_W:0] TEMP_OFFSET = 13'sd315;
    localparam logic signed [4:0]      TEMP_SCALE  = 5'sd11;

    typedef struct packed {
        logic [CODE_W-1:0]   field_x;
        logic [CODE_W-1:0]   field_y;
        logic [CODE_W-1:0]   field_z;
        logic [CODE_W-1:0]   temp_code;
        logic [TENTHS_W-1:0] temp_tenths;
    } t_codes;

    typedef struct packed {
        logic              valid;
        t_codes            codes;
        logic [SQ_W-1:0]   rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_root_beat;

endpackage

@@ sv/magnetic_sensor_frame_decode_unit.sv @@
// ----------------------------------------------------------------------------
// magnetic_sensor_frame_decode_unit
// Decodes one 3-axis Hall sensor frame into signed codes, field magnitude
// and temperature in tenths of a degree.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  frame     in         start, busy          seven frame bytes
//  result    out        o_valid (strobe)     x/y/z/temp codes, magnitude, tenths
//
//  one frame per cycle; each start beat reaches the result channel through the register stages
//  (3 front stages for unpack, square and sum, 6 root stages of 2 bits each)
//  busy is always low: the pipeline never holds and the receiver cannot stall
//  synchronous active-low reset clears the valid bits only
// ----------------------------------------------------------------------------
module magnetic_sensor_frame_decode_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_x_high,
    input  logic [7:0]  i_y_high,
    input  logic [7:0]  i_z_high,
    input  logic [7:0]  i_temp_nibble_byte,
    input  logic [7:0]  i_xy_low,
    input  logic [7:0]  i_z_low,
    input  logic [7:0]  i_temp_low,
    output logic        o_valid,
    output logic signed [11:0] o_field_x,
    output logic signed [11:0] o_field_y,
    output logic signed [11:0] o_field_z,
    output logic signed [11:0] o_temp_code,
    output logic        [11:0] o_magnitude,
    output logic signed [15:0] o_temp_tenths
);

    msfd_pkg::t_root_beat w_front;
    msfd_pkg::t_root_beat w_back;

    assign busy = 1'b0;

    msfd_unpack u_unpack (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (start && !busy),
        .i_x_high           (i_x_high),
        .i_y_high           (i_y_high),
        .i_z_high           (i_z_high),
        .i_temp_nibble_byte (i_temp_nibble_byte),
        .i_xy_low           (i_xy_low),
        .i_z_low            (i_z_low),
        .i_temp_low         (i_temp_low),
        .o_beat             (w_front)
    );

    msfd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_front),
        .o_beat  (w_back)
    );

    assign o_valid       = w_back.valid;
    assign o_field_x     = $signed(w_back.codes.field_x);
    assign o_field_y     = $signed(w_back.codes.field_y);
    assign o_field_z     = $signed(w_back.codes.field_z);
    assign o_temp_code   = $signed(w_back.codes.temp_code);
    assign o_magnitude   = w_back.root;
    assign o_temp_tenths = $signed(w_back.codes.temp_tenths);

    // every accepted beat comes out as a result beat
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(msfd_pkg::LATENCY) o_valid)
        else $error("accepted beat did not reach the output");

    // every result beat stems from an accepted start beat
    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, msfd_pkg::LATENCY))
        else $error("result beat without a matching start");

    // magnitude bounded by the largest possible field vector
    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_magnitude <= 12'd3547))
        else $error("magnitude out of range");

    // tenths path and code path stay aligned through the stages
    a_tenths_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(signed'(o_temp_tenths))
                     == (32'(signed'(o_temp_code)) - 32'sd315) * 32'sd11))
        else $error("temperature tenths do not match temperature code");

    // the root is never too large for the field codes
    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_magnitude) * int'(o_magnitude)
                     <= int'(o_field_x) * int'(o_field_x)
                        + int'(o_field_y) * int'(o_field_y)
                        + int'(o_field_z) * int'(o_field_z)))
        else $error("magnitude exceeds square root of sum");

endmodule

@@ sv/msfd_unpack.sv @@
// ----------------------------------------------------------------------------
// msfd_unpack
// Front end: assembles the four codes, squares the field codes, offsets the
// temperature, then sums the squares into the radicand and scales temperature.
// ----------------------------------------------------------------------------
module msfd_unpack (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [msfd_pkg::BYTE_W-1:0] i_x_high,
    input  logic [msfd_pkg::BYTE_W-1:0] i_y_high,
    input  logic [msfd_pkg::BYTE_W-1:0] i_z_high,
    input  logic [msfd_pkg::BYTE_W-1:0] i_temp_nibble_byte,
    input  logic [msfd_pkg::BYTE_W-1:0] i_xy_low,
    input  logic [msfd_pkg::BYTE_W-1:0] i_z_low,
    input  logic [msfd_pkg::BYTE_W-1:0] i_temp_low,
    output msfd_pkg::t_root_beat        o_beat
);

    localparam int unsigned CW = msfd_pkg::CODE_W;
    localparam int unsigned SW = msfd_pkg::SQ_W;

    // stage 1: codes
    logic          r_v1;
    logic [CW-1:0] r_cx, r_cy, r_cz, r_ct;

    // stage 2: squares and offset temperature
    logic          r_v2;
    msfd_pkg::t_codes r_codes2;
    logic [SW-1:0] r_sqx, r_sqy, r_sqz;
    logic signed [CW:0] r_tdiff;

    // stage 3: radicand and tenths
    msfd_pkg::t_root_beat r_beat;

    logic signed [2*CW-1:0] n_sqx, n_sqy, n_sqz;
    logic signed [CW:0]     n_tdiff;
    logic signed [CW+5:0]   n_tenths;
    logic [SW-1:0]          n_sum;

    always_comb begin
        n_sqx   = $signed(r_cx) * $signed(r_cx);
        n_sqy   = $signed(r_cy) * $signed(r_cy);
        n_sqz   = $signed(r_cz) * $signed(r_cz);
        n_tdiff = $signed({r_ct[CW-1], r_ct}) - msfd_pkg::TEMP_OFFSET;
        n_tenths = r_tdiff * msfd_pkg::TEMP_SCALE;
        n_sum   = r_sqx + r_sqy + r_sqz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_beat.valid <= 1'b0;
        end else begin
            r_v1         <= i_valid;
            r_v2         <= r_v1;
            r_beat.valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx <= {i_x_high, i_xy_low[7:4]};
        r_cy <= {i_y_high, i_xy_low[3:0]};
        r_cz <= {i_z_high, i_z_low[3:0]};
        r_ct <= {i_temp_nibble_byte[7:4], i_temp_low};

        r_codes2.field_x     <= r_cx;
        r_codes2.field_y     <= r_cy;
        r_codes2.field_z     <= r_cz;
        r_codes2.temp_code   <= r_ct;
        r_codes2.temp_tenths <= '0;
        r_sqx   <= n_sqx;
        r_sqy   <= n_sqy;
        r_sqz   <= n_sqz;
        r_tdiff <= n_tdiff;

        r_beat.codes <= {r_codes2.field_x, r_codes2.field_y, r_codes2.field_z,
                         r_codes2.temp_code, n_tenths[msfd_pkg::TENTHS_W-1:0]};
        r_beat.rad   <= n_sum;
        r_beat.rem   <= '0;
        r_beat.root  <= '0;
    end

    assign o_beat = r_beat;

endmodule

@@ sv/msfd_sqrt_stage.sv @@
// ----------------------------------------------------------------------------
// msfd_sqrt_stage
// One register stage of the digit-by-digit square root, resolving two
// root bits from the top bit pairs of the radicand.
// ----------------------------------------------------------------------------
module msfd_sqrt_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msfd_pkg::t_root_beat i_beat,
    output msfd_pkg::t_root_beat o_beat
);

    localparam int unsigned RW  = msfd_pkg::REM_W;
    localparam int unsigned QW  = msfd_pkg::ROOT_W;
    localparam int unsigned SW  = msfd_pkg::SQ_W;
    localparam int unsigned NB  = msfd_pkg::SQRT_BITS_PER_STAGE;

    msfd_pkg::t_root_beat r_beat;
    msfd_pkg::t_root_beat n_beat;

    always_comb begin
        logic [RW+2:0] trial;
        logic [1:0]    pair;
        n_beat = i_beat;
        for (int k = 0; k < NB; k++) begin
            pair  = n_beat.rad[SW-1 -: 2];
            trial = {1'b0, n_beat.rem, pair} - {2'b00, n_beat.root, 2'b01};
            // remainder stays at most twice the root, so truncation is safe
            if (!trial[RW+2]) begin
                n_beat.rem  = trial[RW-1:0];
                n_beat.root = {n_beat.root[QW-2:0], 1'b1};
            end else begin
                n_beat.rem  = {n_beat.rem[RW-3:0], pair};
                n_beat.root = {n_beat.root[QW-2:0], 1'b0};
            end
            n_beat.rad = {n_beat.rad[SW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= n_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat.codes <= n_beat.codes;
        r_beat.rad   <= n_beat.rad;
        r_beat.rem   <= n_beat.rem;
        r_beat.root  <= n_beat.root;
    end

    assign o_beat = r_beat;

endmodule

@@ sv/msfd_sqrt.sv @@
// ----------------------------------------------------------------------------
// msfd_sqrt
// Chain of square root stages from radicand to floor root.
// ----------------------------------------------------------------------------
module msfd_sqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msfd_pkg::t_root_beat i_beat,
    output msfd_pkg::t_root_beat o_beat
);

    msfd_pkg::t_root_beat w_chain [msfd_pkg::SQRT_STAGES+1];

    assign w_chain[0] = i_beat;

    for (genvar s = 0; s < msfd_pkg::SQRT_STAGES; s++) begin : g_stage
        msfd_sqrt_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_chain[s]),
            .o_beat  (w_chain[s+1])
        );
    end

    assign o_beat = w_chain[msfd_pkg::SQRT_STAGES];

endmodule

@@ verif/msfd_frame_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msfd_frame_checker
// Watches the frame and result channels of the Hall sensor frame decoder.
// Decodes each accepted frame on its own, queues the decoded codes, and
// compares every result beat field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module msfd_frame_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [7:0]         i_x_high,
    input  logic [7:0]         i_y_high,
    input  logic [7:0]         i_z_high,
    input  logic [7:0]         i_temp_nibble_byte,
    input  logic [7:0]         i_xy_low,
    input  logic [7:0]         i_z_low,
    input  logic [7:0]         i_temp_low,
    input  logic               i_valid,
    input  logic signed [11:0] i_field_x,
    input  logic signed [11:0] i_field_y,
    input  logic signed [11:0] i_field_z,
    input  logic signed [11:0] i_temp_code,
    input  logic        [11:0] i_magnitude,
    input  logic signed [15:0] i_temp_tenths,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [11:0] field_x;
        logic [11:0] field_y;
        logic [11:0] field_z;
        logic [11:0] temp_code;
        logic [11:0] magnitude;
        logic [15:0] temp_tenths;
    } t_decoded;

    t_decoded decoded_q[$];
    int       mismatch_total = 0;

    assign o_fail_count = mismatch_total;
    initial o_pending = 0;

    function automatic t_decoded decode_frame(
        logic [7:0] x_high, logic [7:0] y_high, logic [7:0] z_high,
        logic [7:0] temp_nibble_byte, logic [7:0] xy_low,
        logic [7:0] z_low, logic [7:0] temp_low
    );
        t_decoded    d;
        int          vx;
        int          vy;
        int          vz;
        int          vt;
        int unsigned sum_sq;
        int unsigned root;
        int unsigned trial;
        int          tenths;
        d.field_x   = {x_high, xy_low[7:4]};
        d.field_y   = {y_high, xy_low[3:0]};
        d.field_z   = {z_high, z_low[3:0]};
        d.temp_code = {temp_nibble_byte[7:4], temp_low};
        vx = int'($signed(d.field_x));
        vy = int'($signed(d.field_y));
        vz = int'($signed(d.field_z));
        vt = int'($signed(d.temp_code));
        sum_sq = vx * vx + vy * vy + vz * vz;
        // floor root: settle one bit at a time from the top
        root = 0;
        for (int b = 11; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= sum_sq) begin
                root = trial;
            end
        end
        d.magnitude = root[11:0];
        tenths = (vt - int'(msfd_pkg::TEMP_OFFSET)) * int'(msfd_pkg::TEMP_SCALE);
        d.temp_tenths = tenths[15:0];
        return d;
    endfunction

    task automatic check_field(string name, int expected, int actual);
        if (expected != actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin : watch_beats
        t_decoded want;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                decoded_q.push_back(decode_frame(i_x_high, i_y_high, i_z_high,
                    i_temp_nibble_byte, i_xy_low, i_z_low, i_temp_low));
            end
            if (i_valid) begin
                if (decoded_q.size() == 0) begin
                    $error("result beat with no frame outstanding");
                    mismatch_total++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("field_x", int'($signed(want.field_x)), int'(i_field_x));
                    check_field("field_y", int'($signed(want.field_y)), int'(i_field_y));
                    check_field("field_z", int'($signed(want.field_z)), int'(i_field_z));
                    check_field("temp_code", int'($signed(want.temp_code)),
                                int'(i_temp_code));
                    check_field("magnitude", int'(want.magnitude), int'(i_magnitude));
                    check_field("temp_tenths", int'($signed(want.temp_tenths)),
                                int'(i_temp_tenths));
                end
            end
        end
        o_pending <= decoded_q.size();
    end

endmodule

@@ verif/tb_magnetic_sensor_frame_decode_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_magnetic_sensor_frame_decode_unit
// Drives sensor frames into the decoder: a directed set of edge codes, then
// random frames with sender gaps, one full drain midway and a gap-free tail.
// The checker beside the block decides each result; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_magnetic_sensor_frame_decode_unit;

    localparam int NUM_RANDOM = 400;
    localparam int IDLE_FREE  = 60;

    typedef struct packed {
        logic [7:0] x_high;
        logic [7:0] y_high;
        logic [7:0] z_high;
        logic [7:0] temp_nibble_byte;
        logic [7:0] xy_low;
        logic [7:0] z_low;
        logic [7:0] temp_low;
    } t_frame;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    logic [7:0]  i_x_high           = '0;
    logic [7:0]  i_y_high           = '0;
    logic [7:0]  i_z_high           = '0;
    logic [7:0]  i_temp_nibble_byte = '0;
    logic [7:0]  i_xy_low           = '0;
    logic [7:0]  i_z_low            = '0;
    logic [7:0]  i_temp_low         = '0;
    logic        o_valid;
    logic signed [11:0] o_field_x;
    logic signed [11:0] o_field_y;
    logic signed [11:0] o_field_z;
    logic signed [11:0] o_temp_code;
    logic        [11:0] o_magnitude;
    logic signed [15:0] o_temp_tenths;
    int          fail_count;
    int          frames_outstanding;

    always #10 i_clk = ~i_clk;

    magnetic_sensor_frame_decode_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_x_high           (i_x_high),
        .i_y_high           (i_y_high),
        .i_z_high           (i_z_high),
        .i_temp_nibble_byte (i_temp_nibble_byte),
        .i_xy_low           (i_xy_low),
        .i_z_low            (i_z_low),
        .i_temp_low         (i_temp_low),
        .o_valid            (o_valid),
        .o_field_x          (o_field_x),
        .o_field_y          (o_field_y),
        .o_field_z          (o_field_z),
        .o_temp_code        (o_temp_code),
        .o_magnitude        (o_magnitude),
        .o_temp_tenths      (o_temp_tenths)
    );

    msfd_frame_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_x_high           (i_x_high),
        .i_y_high           (i_y_high),
        .i_z_high           (i_z_high),
        .i_temp_nibble_byte (i_temp_nibble_byte),
        .i_xy_low           (i_xy_low),
        .i_z_low            (i_z_low),
        .i_temp_low         (i_temp_low),
        .i_valid            (o_valid),
        .i_field_x          (o_field_x),
        .i_field_y          (o_field_y),
        .i_field_z          (o_field_z),
        .i_temp_code        (o_temp_code),
        .i_magnitude        (o_magnitude),
        .i_temp_tenths      (o_temp_tenths),
        .o_fail_count       (fail_count),
        .o_pending          (frames_outstanding)
    );

    // pack codes into frame bytes, unused nibbles get noise
    function automatic t_frame pack_frame(logic [11:0] cx, logic [11:0] cy,
                                          logic [11:0] cz, logic [11:0] ct);
        t_frame f;
        f.x_high           = cx[11:4];
        f.y_high           = cy[11:4];
        f.z_high           = cz[11:4];
        f.xy_low           = {cx[3:0], cy[3:0]};
        f.z_low            = {4'($urandom_range(0, 15)), cz[3:0]};
        f.temp_nibble_byte = {ct[11:8], 4'($urandom_range(0, 15))};
        f.temp_low         = ct[7:0];
        return f;
    endfunction

    function automatic logic [11:0] near_zero_code();
        return 12'(int'($urandom_range(0, 40)) - 20);
    endfunction

    function automatic logic [11:0] near_rail_code();
        logic [11:0] offs;
        offs = 12'($urandom_range(0, 3));
        return $urandom_range(0, 1) ? 12'h7FF - offs : 12'h800 + offs;
    endfunction

    task automatic send_frame(t_frame f);
        @(negedge i_clk);
        start              <= 1'b1;
        i_x_high           <= f.x_high;
        i_y_high           <= f.y_high;
        i_z_high           <= f.z_high;
        i_temp_nibble_byte <= f.temp_nibble_byte;
        i_xy_low           <= f.xy_low;
        i_z_low            <= f.z_low;
        i_temp_low         <= f.temp_low;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
    endtask

    task automatic sender_gap(int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        t_frame      f;
        logic [11:0] cx;
        logic [11:0] cy;
        logic [11:0] cz;
        logic [11:0] ct;
        logic [63:0] raw;
        int          kind;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // directed: zero, rails, unused nibbles, temperature at its offset
        send_frame('0);
        send_frame('1);
        send_frame(pack_frame(12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF));
        send_frame(pack_frame(12'h800, 12'h800, 12'h800, 12'h800));
        send_frame(pack_frame(12'h800, 12'h7FF, 12'h800, 12'h000));
        send_frame(pack_frame(12'hFFF, 12'h001, 12'hFFF, 12'hFFF));
        send_frame(pack_frame(12'd3, 12'd4, 12'd0, 12'd315));
        send_frame(pack_frame(12'hFFD, 12'd4, 12'd12, 12'd314));
        send_frame(pack_frame(12'd1, 12'd1, 12'd1, 12'd316));
        send_frame(pack_frame(12'd2, 12'd3, 12'd6, 12'h100));
        send_frame(pack_frame(12'h555, 12'hAAA, 12'h0F0, 12'hA5A));
        send_frame(pack_frame(12'hAAA, 12'h555, 12'hF0F, 12'h5A5));
        send_frame('{x_high: 8'h00, y_high: 8'h00, z_high: 8'h00,
                     temp_nibble_byte: 8'h0F, xy_low: 8'h00, z_low: 8'hF0,
                     temp_low: 8'h00});
        send_frame('{x_high: 8'hFF, y_high: 8'hFF, z_high: 8'hFF,
                     temp_nibble_byte: 8'hF0, xy_low: 8'hFF, z_low: 8'h0F,
                     temp_low: 8'hFF});
        send_frame(pack_frame(12'h400, 12'hC00, 12'h000, 12'h7FF));
        send_frame(pack_frame(12'h000, 12'h000, 12'h800, 12'h800));

        for (int idx = 0; idx < NUM_RANDOM; idx++) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                raw = {$urandom, $urandom};
                f   = raw[55:0];
            end else begin
                cx = (kind < 7) ? near_zero_code() : near_rail_code();
                cy = $urandom_range(0, 2) == 0 ? 12'($urandom) :
                     (kind < 7) ? near_zero_code() : near_rail_code();
                cz = (kind < 7) ? near_zero_code() : near_rail_code();
                ct = $urandom_range(0, 1) ? 12'($urandom) :
                     12'(315 + int'($urandom_range(0, 6)) - 3);
                f = pack_frame(cx, cy, cz, ct);
            end
            send_frame(f);

            if (idx == NUM_RANDOM / 2) begin
                // let the pipeline run dry before carrying on
                sender_gap(1);
                wait (frames_outstanding == 0);
            end else if (idx < NUM_RANDOM - IDLE_FREE && $urandom_range(0, 3) == 0) begin
                sender_gap($urandom_range(1, 12));
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        wait (frames_outstanding == 0);
        repeat (msfd_pkg::LATENCY + 4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
